@@ rtl/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is held
`define WMSD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define WMSD_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wmsd_pkg.sv @@
// shared types, constants and codes for the weighted mean / std-dev block
package wmsd_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int MAX_MEMBERS = 4096;
  localparam int ID_W        = 13;
  localparam int WGT_W       = 16;
  localparam int VAL_W       = 16;
  localparam int ENTRY_W     = 1 + WGT_W + VAL_W;
  localparam int WSUM_W      = 28;
  localparam int WV_W        = 44;
  localparam int SQ_W        = 60;
  localparam int DIV_STEPS   = 60;
  localparam int SQRT_STEPS  = 30;
  localparam int STEP_W      = 6;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_MEMBER = 2'd1,
    ACT_EMPTY  = 2'd2,
    ACT_RSVD   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_DIV_MEAN,
    ST_MEAN,
    ST_DIV_SQ,
    ST_VAR,
    ST_SQRT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [12:0]       entry_id;
    logic [15:0]       entry_weight;
    logic signed [15:0] entry_value;
    logic              entry_missing;
    logic [23:0]       cell_id;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [23:0]        out_cell_id;
    logic [12:0]        member_count;
    logic               has_data;
    logic signed [15:0] mean;
    logic [27:0]        weight_sum;
    logic [15:0]        std_dev;
    logic               zero_weight;
    logic               id_overflow;
  } out_word_t;

  typedef struct packed {
    logic load_wr;
    logic member_start;
    logic empty_start;
    logic mul1;
    logic mul2;
    logic acc;
    logic div_mean_load;
    logic div_step;
    logic mean_calc;
    logic var_calc;
    logic sqrt_step;
    logic emit;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic wt_zero;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/wmsd_ram.sv @@
// generic single-write, single-read ram with registered read data
module wmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/wmsd_ctrl.sv @@
// controller state machine sequencing loads, members and the final statistics
module wmsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  input  logic              in_last,
  input  wmsd_pkg::stat_t   stat,
  output logic              in_stall,
  output wmsd_pkg::cmd_t    cmd
);

  wmsd_pkg::state_t             state_r, state_nxt;
  logic [wmsd_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         last_r, last_nxt;
  logic                         empty_r, empty_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmsd_pkg::ST_IDLE;
      step_r  <= '0;
      last_r  <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
      empty_r <= empty_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    empty_nxt = empty_r;
    cmd       = '0;
    in_stall  = (state_r != wmsd_pkg::ST_IDLE);
    unique case (state_r)
      wmsd_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            wmsd_pkg::ACT_LOAD: begin
              cmd.load_wr = 1'b1;
            end
            wmsd_pkg::ACT_MEMBER: begin
              cmd.member_start = 1'b1;
              last_nxt         = in_last;
              empty_nxt        = 1'b0;
              state_nxt        = wmsd_pkg::ST_READ;
            end
            wmsd_pkg::ACT_EMPTY: begin
              cmd.empty_start = 1'b1;
              empty_nxt       = 1'b1;
              state_nxt       = wmsd_pkg::ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      wmsd_pkg::ST_READ: begin
        cmd.mul1  = 1'b1;
        state_nxt = wmsd_pkg::ST_MUL;
      end
      wmsd_pkg::ST_MUL: begin
        cmd.mul2  = 1'b1;
        state_nxt = wmsd_pkg::ST_ACC;
      end
      wmsd_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        priority if (!last_r) begin
          state_nxt = wmsd_pkg::ST_IDLE;
        end else if (stat.wt_zero) begin
          state_nxt = wmsd_pkg::ST_EMIT;
        end else begin
          cmd.div_mean_load = 1'b1;
          step_nxt          = '0;
          state_nxt         = wmsd_pkg::ST_DIV_MEAN;
        end
      end
      wmsd_pkg::ST_DIV_MEAN: begin
        cmd.div_step = 1'b1;
        if (step_r == wmsd_pkg::STEP_W'(wmsd_pkg::DIV_STEPS - 1)) begin
          state_nxt = wmsd_pkg::ST_MEAN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      wmsd_pkg::ST_MEAN: begin
        cmd.mean_calc = 1'b1;
        step_nxt      = '0;
        state_nxt     = wmsd_pkg::ST_DIV_SQ;
      end
      wmsd_pkg::ST_DIV_SQ: begin
        cmd.div_step = 1'b1;
        if (step_r == wmsd_pkg::STEP_W'(wmsd_pkg::DIV_STEPS - 1)) begin
          state_nxt = wmsd_pkg::ST_VAR;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      wmsd_pkg::ST_VAR: begin
        cmd.var_calc = 1'b1;
        step_nxt     = '0;
        state_nxt    = wmsd_pkg::ST_SQRT;
      end
      wmsd_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == wmsd_pkg::STEP_W'(wmsd_pkg::SQRT_STEPS - 1)) begin
          state_nxt = wmsd_pkg::ST_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      wmsd_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_empty = empty_r;
          empty_nxt      = 1'b0;
          state_nxt      = wmsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmsd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/wmsd_dp.sv @@
// datapath: entry table, accumulators, shared divider, square root and result register
module wmsd_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wmsd_pkg::cmd_t        cmd,
  input  wmsd_pkg::in_word_t    in_word,
  input  logic                  cfg_we,
  input  logic [12:0]           cfg_data,
  input  logic                  out_stall,
  output wmsd_pkg::stat_t       stat,
  output logic                  out_valid,
  output wmsd_pkg::out_word_t   out_word
);

  // control-like state
  logic [12:0]                     entry_count_r;
  logic [12:0]                     members_seen_r;
  logic                            stopped_r;
  logic                            acc_en_r;
  logic                            out_valid_r;
  logic signed [wmsd_pkg::WV_W-1:0] wv_sum_r;
  logic [wmsd_pkg::SQ_W-1:0]       sq_sum_r;
  logic [wmsd_pkg::WSUM_W-1:0]     weight_total_r;

  // payload registers
  logic [23:0]              cell_r;
  logic signed [32:0]       prod_wv_r;
  logic [31:0]              prod_wa_r;
  logic [15:0]              av_r;
  logic                     en_r;
  logic [47:0]              sq_prod_r;
  logic [59:0]              div_q_r;
  logic [27:0]              div_rem_r;
  logic signed [15:0]       mean_r;
  logic [31:0]              msq_r;
  logic [59:0]              sqrt_op_r;
  logic [31:0]              sqrt_rem_r;
  logic [29:0]              sqrt_root_r;
  wmsd_pkg::out_word_t      out_word_r;

  // table port signals
  logic [12:0]                     id_m1;
  logic [wmsd_pkg::ADDR_W-1:0]     tab_addr;
  logic                            id_in_table;
  logic                            id_in_range;
  logic                            counted;
  logic                            tab_wr;
  logic [wmsd_pkg::ENTRY_W-1:0]    tab_wdata;
  logic [wmsd_pkg::ENTRY_W-1:0]    tab_rdata;

  // member arithmetic
  logic [15:0]              rd_w;
  logic signed [15:0]       rd_v;
  logic                     rd_miss;
  logic [15:0]              rd_av;
  logic                     rd_en_acc;

  // divider, mean and square root step logic
  logic                     wv_neg;
  logic [43:0]              wv_mag;
  logic [28:0]              div_sh;
  logic                     div_ge;
  logic [15:0]              am;
  logic [59:0]              var_val;
  logic [33:0]              sq_sh;
  logic [31:0]              sq_trial;
  logic                     sq_ge;

  // table addressing and range checks
  assign id_m1       = in_word.entry_id - 13'd1;
  assign tab_addr    = id_m1[wmsd_pkg::ADDR_W-1:0];
  assign id_in_table = (in_word.entry_id != 13'd0) &&
                       (in_word.entry_id <= 13'(wmsd_pkg::TABLE_DEPTH));
  assign id_in_range = id_in_table && (in_word.entry_id <= entry_count_r);
  assign counted     = (members_seen_r < 13'(wmsd_pkg::MAX_MEMBERS));
  assign tab_wr      = cmd.load_wr && id_in_table;
  assign tab_wdata   = {in_word.entry_missing, in_word.entry_weight, in_word.entry_value};

  wmsd_ram #(
    .WIDTH (wmsd_pkg::ENTRY_W),
    .DEPTH (wmsd_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tab_wr),
    .wr_addr (tab_addr),
    .wr_data (tab_wdata),
    .rd_en   (cmd.member_start),
    .rd_addr (tab_addr),
    .rd_data (tab_rdata)
  );

  // unpack the entry read back
  assign rd_miss   = tab_rdata[wmsd_pkg::ENTRY_W-1];
  assign rd_w      = tab_rdata[31:16];
  assign rd_v      = tab_rdata[15:0];
  assign rd_av     = rd_v[15] ? (~rd_v + 16'd1) : rd_v;
  assign rd_en_acc = acc_en_r && !rd_miss;

  // divider step: restoring, one quotient bit a cycle
  assign wv_neg = wv_sum_r[wmsd_pkg::WV_W-1];
  assign wv_mag = wv_neg ? (~wv_sum_r + 44'd1) : wv_sum_r;
  assign div_sh = {div_rem_r, div_q_r[59]};
  assign div_ge = (div_sh >= {1'b0, weight_total_r});

  // saturated mean magnitude
  always_comb begin
    if (wv_neg) begin
      am = (div_q_r > 60'd32768) ? 16'h8000 : div_q_r[15:0];
    end else begin
      am = (div_q_r > 60'd32767) ? 16'h7fff : div_q_r[15:0];
    end
  end

  // variance clamp and square root step, two radicand bits a cycle
  assign var_val  = (div_q_r > 60'(msq_r)) ? (div_q_r - 60'(msq_r)) : 60'd0;
  assign sq_sh    = {sqrt_rem_r, sqrt_op_r[59:58]};
  assign sq_trial = {sqrt_root_r, 2'b01};
  assign sq_ge    = (sq_sh >= 34'(sq_trial));

  // status back to the controller
  assign stat.wt_zero  = (weight_total_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

  // registers with reset: register, sums, cell status, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r  <= '0;
      members_seen_r <= '0;
      stopped_r      <= 1'b0;
      acc_en_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      wv_sum_r       <= '0;
      sq_sum_r       <= '0;
      weight_total_r <= '0;
    end else begin
      if (cfg_we) begin
        entry_count_r <= cfg_data;
      end
      if (cmd.member_start) begin
        acc_en_r <= counted && !stopped_r && id_in_range;
        if (counted) begin
          members_seen_r <= members_seen_r + 13'd1;
          if (!stopped_r && !id_in_range) begin
            stopped_r <= 1'b1;
          end
        end
      end
      if (cmd.mul1 && rd_en_acc) begin
        weight_total_r <= weight_total_r + wmsd_pkg::WSUM_W'(rd_w);
      end
      if (cmd.mul2 && en_r) begin
        wv_sum_r <= wv_sum_r + wmsd_pkg::WV_W'(prod_wv_r);
      end
      if (cmd.acc && en_r) begin
        sq_sum_r <= sq_sum_r + wmsd_pkg::SQ_W'(sq_prod_r);
      end
      // result register frees on a taken word, refills on emit
      if (cmd.emit) begin
        out_valid_r    <= 1'b1;
        members_seen_r <= '0;
        stopped_r      <= 1'b0;
        wv_sum_r       <= '0;
        sq_sum_r       <= '0;
        weight_total_r <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.member_start || cmd.empty_start) begin
      cell_r <= in_word.cell_id;
    end
    // first multiply stage
    if (cmd.mul1) begin
      prod_wv_r <= $signed({1'b0, rd_w}) * rd_v;
      prod_wa_r <= rd_w * rd_av;
      av_r      <= rd_av;
      en_r      <= rd_en_acc;
    end
    // second multiply stage
    if (cmd.mul2) begin
      sq_prod_r <= prod_wa_r * av_r;
    end
    // shared divider: load and step, remainder stays below the weight sum
    priority if (cmd.div_mean_load) begin
      div_q_r   <= 60'(wv_mag) + 60'(weight_total_r >> 1);
      div_rem_r <= '0;
    end else if (cmd.mean_calc) begin
      div_q_r   <= sq_sum_r;
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? 28'(div_sh - {1'b0, weight_total_r}) : div_sh[27:0];
      div_q_r   <= {div_q_r[58:0], div_ge};
    end
    // saturated mean and its square
    if (cmd.mean_calc) begin
      mean_r <= wv_neg ? (~am + 16'd1) : am;
      msq_r  <= am * am;
    end
    // square root: load and step
    if (cmd.var_calc) begin
      sqrt_op_r   <= var_val;
      sqrt_rem_r  <= '0;
      sqrt_root_r <= '0;
    end else if (cmd.sqrt_step) begin
      sqrt_op_r   <= {sqrt_op_r[57:0], 2'b00};
      sqrt_rem_r  <= sq_ge ? 32'(sq_sh - 34'(sq_trial)) : sq_sh[31:0];
      sqrt_root_r <= {sqrt_root_r[28:0], sq_ge};
    end
    // result word
    if (cmd.emit) begin
      out_word_r             <= '0;
      out_word_r.out_cell_id <= cell_r;
      if (!cmd.emit_empty) begin
        out_word_r.member_count <= members_seen_r;
        out_word_r.has_data     <= 1'b1;
        out_word_r.id_overflow  <= stopped_r;
        if (stat.wt_zero) begin
          out_word_r.zero_weight <= 1'b1;
        end else begin
          out_word_r.mean       <= mean_r;
          out_word_r.weight_sum <= weight_total_r;
          out_word_r.std_dev    <= sqrt_root_r[15:0];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/weighted_mean_stddev_per_group.sv @@
// weighted mean and std-dev per cell: top level joining controller and datapath
// load and ignored words are taken in idle; a member word passes a table read and two multiply stages
// a last member adds two 60-step divisions and a 30-step root; a zero weight sum goes to emit
// an empty cell word is registered via the emit state; a held result word delays the emit
// synchronous active-low reset clears control, sums and the register; the table is not cleared
module weighted_mean_stddev_per_group (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wmsd_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wmsd_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_data
);

  wmsd_pkg::cmd_t  cmd;
  wmsd_pkg::stat_t stat;

  // sequencing
  wmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_word.action),
    .in_last   (in_word.last),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // arithmetic and storage
  wmsd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

@@ rtl/wmsd_chk.sv @@
// port-level checker for the weighted mean / std-dev block, bound to the top level
`include "assert_macros.svh"

module wmsd_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input wmsd_pkg::out_word_t out_word
);

  `WMSD_ASSERT_RST(a_rst_no_out, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `WMSD_ASSERT(a_hold_valid, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled word dropped")
  `WMSD_ASSERT(a_hold_word, clk, rst_n, out_valid && out_stall |=> $stable(out_word), "stalled word changed")
  `WMSD_ASSERT(a_empty_zero, clk, rst_n, out_valid && !out_word.has_data |-> out_word.member_count == 13'd0 && out_word.weight_sum == 28'd0 && !out_word.zero_weight && !out_word.id_overflow, "empty cell word not cleared")
  `WMSD_ASSERT(a_zero_wt, clk, rst_n, out_valid && out_word.zero_weight |-> out_word.has_data && out_word.mean == 16'sd0 && out_word.weight_sum == 28'd0 && out_word.std_dev == 16'd0, "zero weight word carries statistics")

endmodule

bind weighted_mean_stddev_per_group wmsd_chk u_chk (.*);

@@ sim/tb.sv @@
// testbench for the weighted mean and std-dev per cell block
`timescale 1ns / 1ps

module tb;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  wmsd_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wmsd_pkg::out_word_t out_word;
  logic                cfg_we = 1'b0;
  logic [12:0]         cfg_data = '0;

  weighted_mean_stddev_per_group dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0]        tbl_w [wmsd_pkg::TABLE_DEPTH];
  logic signed [15:0] tbl_v [wmsd_pkg::TABLE_DEPTH];
  logic               tbl_m [wmsd_pkg::TABLE_DEPTH];
  bit                 tbl_set [wmsd_pkg::TABLE_DEPTH];
  logic [12:0] n_entries;
  longint sum_wv;
  longint unsigned sum_wvv, sum_w;
  int unsigned n_members;
  bit halted;

  wmsd_pkg::in_word_t  pending_words[$];
  wmsd_pkg::out_word_t expected_words[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_send = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_sums();
    sum_wv = 0; sum_wvv = 0; sum_w = 0; n_members = 0; halted = 0;
  endfunction

  // work out the result of one accepted word
  function automatic void predict_stats(wmsd_pkg::in_word_t w);
    wmsd_pkg::out_word_t r;
    int idx;
    longint unsigned wt, av, mag, q, ex2, msq, var_q;
    longint mn;
    bit neg;
    r = '0;
    idx = int'(w.entry_id) - 1;
    if (w.action == wmsd_pkg::ACT_LOAD) begin
      if (w.entry_id >= 1 && w.entry_id <= wmsd_pkg::TABLE_DEPTH) begin
        tbl_w[idx] = w.entry_weight;
        tbl_v[idx] = w.entry_value;
        tbl_m[idx] = w.entry_missing;
        tbl_set[idx] = 1;
      end
      return;
    end
    if (w.action == wmsd_pkg::ACT_EMPTY) begin
      clear_sums();
      r.out_cell_id = w.cell_id;
      expected_words = {expected_words, r};
      return;
    end
    if (w.action != wmsd_pkg::ACT_MEMBER) return;
    if (n_members < wmsd_pkg::MAX_MEMBERS) begin
      n_members++;
      if (!halted) begin
        if (w.entry_id < 1 || w.entry_id > n_entries ||
            w.entry_id > wmsd_pkg::TABLE_DEPTH)
          halted = 1;
        else if (!tbl_m[idx]) begin
          wt = tbl_w[idx];
          av = (tbl_v[idx] < 0) ? -longint'(tbl_v[idx]) : longint'(tbl_v[idx]);
          sum_wv += longint'(wt) * longint'(tbl_v[idx]);
          sum_wvv += wt * av * av;
          sum_w += wt;
        end
      end
    end
    if (!w.last) return;
    r.out_cell_id = w.cell_id;
    r.member_count = n_members[12:0];
    r.has_data = 1;
    r.id_overflow = halted;
    if (sum_w == 0) begin
      r.zero_weight = 1;
    end else begin
      neg = sum_wv < 0;
      mag = neg ? longint'(-sum_wv) : longint'(sum_wv);
      q = (mag + sum_w / 2) / sum_w;
      if (neg) mn = (q > 32768) ? -32768 : -longint'(q);
      else mn = (q > 32767) ? 32767 : longint'(q);
      ex2 = sum_wvv / sum_w;
      msq = (mn < 0 ? -mn : mn) * (mn < 0 ? -mn : mn);
      var_q = ex2 > msq ? ex2 - msq : 0;
      r.mean = mn[15:0];
      r.weight_sum = (sum_w > 64'h0FFFFFFF) ? 28'hFFFFFFF : sum_w[27:0];
      r.std_dev = 16'(int_sqrt(var_q));
    end
    expected_words = {expected_words, r};
    clear_sums();
  endfunction

  // accepted input words feed the predictor at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      predict_stats(in_word);
      items_sent++;
    end
  end

  // driver: present queued words, change at the falling edge
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_words.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: compare results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_word);
      end else begin
        if (out_word !== expected_words[0]) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected %p actual %p", expected_words[0], out_word);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [12:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_entries = v;
  endtask

  function automatic wmsd_pkg::in_word_t make_word(logic [1:0] a, int id, int cell_num,
                                                   bit lst);
    wmsd_pkg::in_word_t w;
    w = '0;
    w.action = a;
    w.entry_id = 13'(id);
    w.cell_id = 24'(cell_num);
    w.last = lst;
    w.entry_weight = 16'($urandom);
    w.entry_value = 16'($urandom);
    w.entry_missing = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic queue_word(wmsd_pkg::in_word_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic queue_load(int id, int wt, int v, bit m);
    wmsd_pkg::in_word_t w;
    w = make_word(wmsd_pkg::ACT_LOAD, id, int'($urandom), 1'($urandom_range(1)));
    w.entry_weight = 16'(wt);
    w.entry_value = 16'(v);
    w.entry_missing = m;
    queue_word(w);
  endtask

  // one cell of random members drawn from written entries, some out of range
  task automatic queue_cell(int span, int len);
    int id, c;
    c = int'($urandom);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) id = int'($urandom_range(8191));
      else id = int'($urandom_range(span, 1));
      queue_word(make_word(wmsd_pkg::ACT_MEMBER, id, c, k == len - 1));
    end
  endtask

  initial begin
    int span, phase;
    wmsd_pkg::in_word_t w;
    for (int i = 0; i < wmsd_pkg::TABLE_DEPTH; i++) tbl_set[i] = 0;
    n_entries = 0;
    clear_sums();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: extremes and special cases
    write_entry_count(13'd4096);
    queue_load(1, 16'hFFFF, 16'sh7FFF, 0);
    queue_load(2, 16'hFFFF, -32768, 0);
    queue_load(3, 0, 100, 0);
    queue_load(4, 256, 256, 1);
    queue_load(4096, 16'h0100, -256, 0);
    queue_load(0, 1, 1, 0);
    queue_load(4097, 1, 1, 0);
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 1, 24'hFFFFFF, 0));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 2, 24'hFFFFFF, 0));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 4096, 24'hFFFFFF, 1));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 3, 24'h000001, 1));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 4, 24'h000002, 1));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 1, 24'h000003, 0));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 0, 24'h000003, 0));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 2, 24'h000003, 1));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 1, 24'h000004, 0));
    queue_word(make_word(wmsd_pkg::ACT_EMPTY, 0, 24'h000000, 0));
    w = make_word(wmsd_pkg::ACT_RSVD, 1, 5, 1);
    queue_word(w);
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 8191, 24'h000006, 1));
    wait_drained();
    // id above entry_count, and entry_count zero
    write_entry_count(13'd2);
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 1, 7, 0));
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 3, 7, 1));
    wait_drained();
    write_entry_count(13'd0);
    queue_word(make_word(wmsd_pkg::ACT_MEMBER, 1, 8, 1));
    wait_drained();

    // random part in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 25 : 0;
      span = (phase == 0) ? 16 : (phase == 1) ? 64 : 1 + int'($urandom_range(40));
      write_entry_count(13'(span));
      for (int i = 1; i <= span; i++)
        if (!tbl_set[i - 1] || $urandom_range(3) == 0)
          queue_load(i, int'($urandom), int'($urandom), $urandom_range(5) == 0);
      repeat (14) begin
        if ($urandom_range(9) == 0)
          queue_word(make_word(wmsd_pkg::ACT_EMPTY, int'($urandom), int'($urandom), 1));
        else queue_cell(span, int'($urandom_range(12, 1)));
        if ($urandom_range(9) == 0)
          queue_load(int'($urandom_range(span, 1)), int'($urandom), int'($urandom),
                     1'($urandom_range(1)));
      end
      if (phase == 1) begin
        // sender holds off until every result has come
        hold_send = 1'b1;
        while (in_valid || expected_words.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      queue_cell(span, 6);
      wait_drained();
    end

    $display("sent %0d words and checked %0d results: loads, cells, empty cells,",
             items_sent, results_seen);
    $display("range stops and zero weights under three mixes of sender and receiver idling");
    if (errors == 0) begin
      $display("weighted_mean_stddev_per_group: match");
    end else begin
      $display("weighted_mean_stddev_per_group: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("weighted_mean_stddev_per_group: mismatch");
    $finish;
  end

endmodule
